@@ hdl/running_median_two_heaps_macros.svh @@
// Assertion macros used by the running median top level.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RMH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RMH_ASSERT_IMPL(label, ante, cons, msg) \
  `RMH_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ hdl/rmh_pkg.sv @@
// Types and constants of the running median block.
package rmh_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned HEAP_DEPTH = CAPACITY / 2;
  localparam int unsigned AW         = $clog2(HEAP_DEPTH);
  localparam int unsigned SW         = AW + 1;
  localparam int unsigned CW         = $clog2(CAPACITY) + 1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_SWAP = 1'b1;

  typedef struct packed {
    logic               start;
    logic               op;
    logic signed [31:0] value;
  } heap_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] top;
  } heap_sts_t;

endpackage

@@ hdl/rmh_heap.sv @@
// One binary heap held in a synchronous memory, with push and replace-top walks.
module rmh_heap
  import rmh_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            is_max,
  input  heap_cmd_t       cmd,
  input  logic [SW-1:0]   size,
  output heap_sts_t       sts
);

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_PRD  = 3'd1;
  localparam logic [2:0] H_PCMP = 3'd2;
  localparam logic [2:0] H_SRD  = 3'd3;
  localparam logic [2:0] H_SCMP = 3'd4;

  logic [31:0]        mem [HEAP_DEPTH];
  logic signed [31:0] rd0_r, rd1_r;
  logic [2:0]         st_r, st_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic [SW-1:0]      n_r, n_nxt;
  logic [AW-1:0]      i_r, i_nxt;
  logic signed [31:0] top_r;
  logic               we;
  logic [AW-1:0]      wa, ra0, ra1;
  logic signed [31:0] wd, hc;
  logic [AW-1:0]      par, c;
  logic [SW-1:0]      l;
  logic               done;

  function automatic logic outranks(logic mx, logic signed [31:0] a, logic signed [31:0] b);
    return mx ? (a > b) : (a < b);
  endfunction

  always_comb begin
    st_nxt = st_r;
    v_nxt  = v_r;
    n_nxt  = n_r;
    i_nxt  = i_r;
    we     = 1'b0;
    wa     = i_r;
    wd     = v_r;
    ra0    = '0;
    ra1    = '0;
    done   = 1'b0;
    par    = AW'((i_r - AW'(1)) >> 1);
    l      = {i_r, 1'b1};
    c      = l[AW-1:0];
    hc     = rd0_r;
    unique case (st_r)
      H_IDLE: begin
        if (cmd.start) begin
          v_nxt  = cmd.value;
          n_nxt  = size;
          i_nxt  = (cmd.op == OP_PUSH) ? size[AW-1:0] : '0;
          st_nxt = (cmd.op == OP_PUSH) ? H_PRD : H_SRD;
        end
      end
      H_PRD: begin
        if (i_r == '0) begin
          we = 1'b1; done = 1'b1; st_nxt = H_IDLE;
        end else begin
          ra0 = par; st_nxt = H_PCMP;
        end
      end
      H_PCMP: begin
        we = 1'b1;
        if (outranks(is_max, v_r, rd0_r)) begin
          wd = rd0_r; i_nxt = par; st_nxt = H_PRD;
        end else begin
          done = 1'b1; st_nxt = H_IDLE;
        end
      end
      H_SRD: begin
        if (l >= n_r) begin
          we = 1'b1; done = 1'b1; st_nxt = H_IDLE;
        end else begin
          ra0 = l[AW-1:0]; ra1 = l[AW-1:0] + AW'(1); st_nxt = H_SCMP;
        end
      end
      H_SCMP: begin
        we = 1'b1;
        if ((l + SW'(1) < n_r) && outranks(is_max, rd1_r, rd0_r)) begin
          c = l[AW-1:0] + AW'(1); hc = rd1_r;
        end
        if (outranks(is_max, hc, v_r)) begin
          wd = hc; i_nxt = c; st_nxt = H_SRD;
        end else begin
          done = 1'b1; st_nxt = H_IDLE;
        end
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= H_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    v_r <= v_nxt;
    n_r <= n_nxt;
    i_r <= i_nxt;
    if (we && wa == '0) top_r <= wd;
  end

  assign sts.busy = (st_r != H_IDLE);
  assign sts.done = done;
  assign sts.top  = top_r;

endmodule

@@ hdl/running_median_two_heaps.sv @@
// Top level of the running median: two heaps in memory and the item sequencer.
//
//  channel | ports                                         | direction
//  in      | in_valid, in_stall, in_sample                 | word in
//  out     | out_valid, out_stall, out_median_doubled,     | word out
//          | out_sample_count, out_dropped                 |
//
// An item runs a replace-top walk, when needed, and a push walk; each walk takes
// one tree level per read state and compare state (memory read, compare and
// write back), plus the accept and finish steps.
// A dropped word goes from accept straight to the finish state, which frees the input once its result word is loaded.
// Reset empties both heaps by clearing the size counters; memory keeps its data.
// in_stall is high while an item is in work; out_stall holds the result word
// in the output register, and the next item waits only at its own finish.
module running_median_two_heaps
  import rmh_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] out_median_doubled,
  output logic [CW-1:0]      out_sample_count,
  output logic               out_dropped
);

`include "running_median_two_heaps_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SWAP = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         st_r, st_nxt;
  logic [SW-1:0]      lo_size_r, lo_size_nxt, up_size_r, up_size_nxt;
  logic               to_up_r, to_up_nxt;     // push goes to the upper heap
  logic               drop_r, drop_nxt;
  logic signed [31:0] carry_r, carry_nxt;     // top displaced by the swap walk
  logic               out_valid_r, out_valid_nxt;
  logic signed [32:0] out_med_r;
  logic [CW-1:0]      out_cnt_r;
  logic               out_drop_r;
  logic               load_out;
  heap_cmd_t          lo_cmd, up_cmd;
  heap_sts_t          lo_sts, up_sts;
  logic [CW-1:0]      total;
  logic signed [32:0] med;
  logic               accept;

  assign total  = CW'(lo_size_r) + CW'(up_size_r);
  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE);

  // Even total: sum of the two tops. Odd: twice the upper top.
  assign med = total[0] ? {up_sts.top, 1'b0}
                        : (33'(lo_sts.top) + 33'(up_sts.top));

  rmh_heap u_lo (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_max (1'b1),
    .cmd    (lo_cmd),
    .size   (lo_size_r),
    .sts    (lo_sts)
  );

  rmh_heap u_up (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_max (1'b0),
    .cmd    (up_cmd),
    .size   (up_size_r),
    .sts    (up_sts)
  );

  always_comb begin
    st_nxt        = st_r;
    lo_size_nxt   = lo_size_r;
    up_size_nxt   = up_size_r;
    to_up_nxt     = to_up_r;
    drop_nxt      = drop_r;
    carry_nxt     = carry_r;
    out_valid_nxt = out_valid_r && out_stall;
    load_out      = 1'b0;
    lo_cmd        = '{start: 1'b0, op: OP_PUSH, value: in_sample};
    up_cmd        = '{start: 1'b0, op: OP_PUSH, value: in_sample};
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          drop_nxt = 1'b0;
          if (total >= CW'(CAPACITY)) begin
            drop_nxt = 1'b1;
            st_nxt   = S_DONE;
          end else if (!total[0]) begin
            // Even: route through the lower top into the upper heap.
            to_up_nxt = 1'b1;
            if (lo_size_r != '0 && in_sample < lo_sts.top) begin
              lo_cmd    = '{start: 1'b1, op: OP_SWAP, value: in_sample};
              carry_nxt = lo_sts.top;
              st_nxt    = S_SWAP;
            end else begin
              up_cmd = '{start: 1'b1, op: OP_PUSH, value: in_sample};
              st_nxt = S_PUSH;
            end
          end else begin
            // Odd: route through the upper top into the lower heap.
            to_up_nxt = 1'b0;
            if (up_size_r != '0 && in_sample > up_sts.top) begin
              up_cmd    = '{start: 1'b1, op: OP_SWAP, value: in_sample};
              carry_nxt = up_sts.top;
              st_nxt    = S_SWAP;
            end else begin
              lo_cmd = '{start: 1'b1, op: OP_PUSH, value: in_sample};
              st_nxt = S_PUSH;
            end
          end
        end
      end
      S_SWAP: begin
        // Hand the displaced top to the other heap once the walk lands.
        if (to_up_r && lo_sts.done) begin
          up_cmd = '{start: 1'b1, op: OP_PUSH, value: carry_r};
          st_nxt = S_PUSH;
        end else if (!to_up_r && up_sts.done) begin
          lo_cmd = '{start: 1'b1, op: OP_PUSH, value: carry_r};
          st_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (to_up_r && up_sts.done) begin
          up_size_nxt = up_size_r + SW'(1);
          st_nxt      = S_DONE;
        end else if (!to_up_r && lo_sts.done) begin
          lo_size_nxt = lo_size_r + SW'(1);
          st_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        // Tops are settled here; wait for the output register to free up.
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // The swap walk rewrites entry zero early, so the old top is captured at
  // accept time and carried to the other heap's push.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      lo_size_r   <= '0;
      up_size_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      lo_size_r   <= lo_size_nxt;
      up_size_r   <= up_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
    to_up_r <= to_up_nxt;
    drop_r  <= drop_nxt;
    carry_r <= carry_nxt;
    if (load_out) begin
      out_med_r  <= med;
      out_cnt_r  <= total;
      out_drop_r <= drop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_med_r;
  assign out_sample_count   = out_cnt_r;
  assign out_dropped        = out_drop_r;

  `RMH_ASSERT(a_balance, (up_size_r == lo_size_r) || (up_size_r == lo_size_r + SW'(1)), "heap sizes out of balance")
  `RMH_ASSERT(a_one_walk, !(lo_sts.busy && up_sts.busy), "both heaps walking at once")
  `RMH_ASSERT_IMPL(a_drop_full, out_valid_r && out_drop_r, out_cnt_r == CW'(CAPACITY), "drop below capacity")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the running median block: random stimulus, scoreboard check.
`timescale 1ns / 100ps

// Expected-result store for the running median: mirrors both heaps as one sorted queue.
class median_scoreboard;
  int signed   held[$];     // all samples held, kept sorted ascending
  int unsigned capacity;
  logic signed [32:0] exp_median[$];
  logic [10:0]        exp_count[$];
  logic               exp_dropped[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned drops_seen;

  function new(int unsigned cap);
    capacity = cap;
    errors = 0;
    checked = 0;
    drops_seen = 0;
  endfunction

  // Note an accepted sample word: insert into the sorted set, queue the expected word.
  function void note_sample(logic signed [31:0] s);
    int pos;
    int n;
    logic signed [32:0] med;
    logic drop;
    drop = (held.size() >= capacity);
    if (!drop) begin
      pos = 0;
      while (pos < held.size() && held[pos] <= s) pos++;
      held.insert(pos, s);
    end
    n = held.size();
    // Odd count: twice the upper middle; even: sum of the two middles.
    if (n % 2 == 1)
      med = 33'(held[n/2]) * 2;
    else
      med = 33'(held[n/2 - 1]) + 33'(held[n/2]);
    exp_median.insert(exp_median.size(), med);
    exp_count.insert(exp_count.size(), 11'(n));
    exp_dropped.insert(exp_dropped.size(), drop);
  endfunction

  // Check one accepted result word against the oldest expectation.
  function void check_result(logic signed [32:0] med, logic [10:0] cnt, logic drop);
    if (exp_median.size() == 0) begin
      $display("%0t: unexpected result word: median_doubled %0d count %0d dropped %0b",
               $time, med, cnt, drop);
      errors++;
      return;
    end
    checked++;
    if (drop) drops_seen++;
    if (med !== exp_median[0]) begin
      $display("%0t: median_doubled mismatch: expected %0d actual %0d",
               $time, exp_median[0], med);
      errors++;
    end
    if (cnt !== exp_count[0]) begin
      $display("%0t: sample_count mismatch: expected %0d actual %0d",
               $time, exp_count[0], cnt);
      errors++;
    end
    if (drop !== exp_dropped[0]) begin
      $display("%0t: dropped mismatch: expected %0b actual %0b",
               $time, exp_dropped[0], drop);
      errors++;
    end
    void'(exp_median.pop_front());
    void'(exp_count.pop_front());
    void'(exp_dropped.pop_front());
  endfunction

  function int unsigned pending();
    return exp_median.size();
  endfunction
endclass

module tb;
  import rmh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_WORDS = 1100;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_sample;
  logic               out_valid;
  logic               out_stall;
  logic signed [32:0] out_median_doubled;
  logic [CW-1:0]      out_sample_count;
  logic               out_dropped;

  median_scoreboard sb;
  int unsigned cycles;
  bit          quiet_mode;   // when set, neither side idles
  bit          hold_off_req; // ask the receiver for a long hold-off
  int unsigned words_sent;

  running_median_two_heaps u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_median_doubled (out_median_doubled),
    .out_sample_count   (out_sample_count),
    .out_dropped        (out_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles; end the run as failed once the limit is hit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still pending", cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge: note accepted samples, check results.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_sample(in_sample);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_median_doubled, out_sample_count, out_dropped);
  end

  // Receiver: outside quiet mode stall at random, about 9 percent of the time; hold off for a long stretch on request.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold = 300;
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        // Hold the output for a counted stretch while the sender keeps offering.
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_mode && $urandom_range(99) < 9) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one sample word, with a random gap before it; hold it until accepted.
  task automatic send_sample(input logic signed [31:0] s);
    while (!quiet_mode && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Random sample shaped to hit duplicates, extremes and narrow ranges often.
  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(5))
      0: return 32'sh8000_0000 + $urandom_range(3);
      1: return 32'sh7FFF_FFFF - $urandom_range(3);
      2: return $signed(32'($urandom_range(20))) - 10;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [31:0] directed [];
    sb = new(CAPACITY);
    cycles = 0;
    quiet_mode = 1'b0;
    hold_off_req = 1'b0;
    words_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed opening: extremes, equal values, sums of opposite extremes.
    directed = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 0, -1, 1, 32'sh5555_5555, 32'shAAAA_AAAA,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5, 5, 5, -5};
    foreach (directed[i]) send_sample(directed[i]);

    // Stretch with no idling on either side.
    quiet_mode = 1'b1;
    repeat (80) send_sample(pick_sample());
    quiet_mode = 1'b0;

    // Long receiver hold-off while words keep coming, so the block backs up.
    hold_off_req = 1'b1;
    repeat (20) send_sample(pick_sample());

    // Fill past capacity so the store overflows and words are dropped.
    while (words_sent < RANDOM_WORDS + 17) send_sample(pick_sample());
    in_valid <= 1'b0;

    // Drain: wait for every expected word, then a little for any stray output.
    while (sb.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("Sent %0d sample words (store capacity %0d); checked %0d results, %0d dropped.",
             words_sent, CAPACITY, sb.checked, sb.drops_seen);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
